### hw/rtl/crss_pkg.sv
// Shared types and constants for the Catmull-Rom stroke sampler.
`default_nettype none

package crss_pkg;

    localparam int STEPS_DEFAULT      = 32;
    localparam int COORD_BITS_DEFAULT = 13;
    localparam int ACC_BITS_DEFAULT   = COORD_BITS_DEFAULT + 2 * $clog2(STEPS_DEFAULT + 1) + 6;
    localparam int DIVISOR_DEFAULT    = 2 * STEPS_DEFAULT * STEPS_DEFAULT * STEPS_DEFAULT;

    localparam int FIELD_BITS     = 13;
    localparam int OUT_BITS       = 14;
    localparam int OUT_MAX        = 16383;
    localparam int IN_TDATA_BITS  = 32;
    localparam int OUT_TDATA_BITS = 32;

    typedef struct packed {
        logic shift;
        logic coef;
        logic load_diff;
        logic step;
        logic last;
    } crss_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic pen_down;
        logic out_free;
        logic div_done;
    } crss_stat_t;

endpackage

`default_nettype wire

### hw/rtl/catmull_rom_stroke_sampler.sv
// Top level of the uniform Catmull-Rom stroke sampler.
//
//  channel   direction  transaction                          fields
//  s_axis    in         one pointer position                 point_x, point_y, pen_down
//  m_axis    out        one curve sample, tlast on the final curve_x, curve_y, last_sample
//
// Fill and pen-up items are accepted and leave the controller idle. A drawing item
// is accepted, starts the dividers, waits for the reciprocal division (low half, high
// half, fix), then gives STEPS + 1 samples at one per cycle while m_axis is not stalled.
// Reset clears the window, the fill count and the controller; no clearing pass.
// A stalled m_axis holds the sample in the output register and pauses stepping.
`default_nettype none

module catmull_rom_stroke_sampler #(
    parameter int STEPS      = crss_pkg::STEPS_DEFAULT,
    parameter int COORD_BITS = crss_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [crss_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,  // point_x, point_y
    input  logic                                 s_axis_tuser,  // pen_down
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [crss_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,  // curve_x, curve_y
    output logic                                 m_axis_tlast   // last_sample
);
    import crss_pkg::*;

    localparam int XW = (COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS;

    logic [FIELD_BITS-1:0] in_x, in_y;
    logic [XW-1:0]         x_ext, y_ext;
    logic signed [COORD_BITS-1:0] x_c, y_c;

    crss_cmd_t  cmd;
    crss_stat_t stat;
    logic       ready;
    logic       done_x, done_y;
    logic [OUT_BITS-1:0] smp_x, smp_y;

    logic                out_valid_reg;
    logic [OUT_BITS-1:0] out_x_reg, out_y_reg;
    logic                out_last_reg;

    assign in_x  = s_axis_tdata[FIELD_BITS-1:0];
    assign in_y  = s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS];
    assign x_ext = XW'(in_x);
    assign y_ext = XW'(in_y);
    assign x_c   = x_ext[COORD_BITS-1:0];
    assign y_c   = y_ext[COORD_BITS-1:0];

    assign stat.in_valid = s_axis_tvalid;
    assign stat.pen_down = s_axis_tuser;
    assign stat.out_free = !out_valid_reg || m_axis_tready;
    assign stat.div_done = done_x & done_y;

    crss_ctrl #(.STEPS(STEPS)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .in_ready (ready),
        .cmd      (cmd)
    );

    crss_axis #(.STEPS(STEPS), .COORD_BITS(COORD_BITS)) u_axis_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .point    (x_c),
        .sample   (smp_x),
        .div_done (done_x)
    );

    crss_axis #(.STEPS(STEPS), .COORD_BITS(COORD_BITS)) u_axis_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .point    (y_c),
        .sample   (smp_y),
        .div_done (done_y)
    );

    assign s_axis_tready = ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            out_x_reg    <= smp_x;
            out_y_reg    <= smp_y;
            out_last_reg <= cmd.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_BITS - 2 * OUT_BITS){1'b0}}, out_y_reg, out_x_reg};
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // no new position is taken while samples are being produced
    a_no_accept_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !s_axis_tready)
        else $error("input accepted while sampling");

    // the final sample returns the controller to idle
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && cmd.last) |=> s_axis_tready)
        else $error("controller not idle after final sample");

    // dividers are busy in the cycle after they are started
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.coef |=> !stat.div_done)
        else $error("divider did not start");

    // stepping only into a free output register
    a_step_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (!out_valid_reg || m_axis_tready))
        else $error("sample overwritten in output register");
`endif

endmodule

`default_nettype wire

### hw/rtl/crss_div.sv
// Division by a constant through a reciprocal multiply, floor quotient with non-negative remainder.
`default_nettype none

module crss_div #(
    parameter int WIDTH      = crss_pkg::ACC_BITS_DEFAULT,
    parameter int DIVISOR    = crss_pkg::DIVISOR_DEFAULT,
    localparam int REM_BITS  = $clog2(DIVISOR + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [WIDTH-1:0]    dividend,
    output logic                       done,
    output logic signed [WIDTH-1:0]    quotient,
    output logic        [REM_BITS-1:0] remainder
);
    import crss_pkg::*;

    localparam int LB = $clog2(DIVISOR);
    localparam int SH = WIDTH + LB;
    localparam int RW = WIDTH + 1;
    localparam int PW = 2 * WIDTH + 1;
    localparam int LO = WIDTH / 2;
    // ceil(2^SH / DIVISOR) is exact for every magnitude below 2^WIDTH
    localparam longint unsigned RECIP_L =
        ((64'd1 << SH) + longint'(DIVISOR) - 64'd1) / longint'(DIVISOR);
    localparam logic [RW-1:0]       RECIP = RW'(RECIP_L);
    localparam logic [WIDTH-1:0]    DIV_W = WIDTH'(DIVISOR);
    localparam logic [REM_BITS-1:0] DIV_R = REM_BITS'(DIVISOR);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_FIX  = 2'd1;
    localparam logic [1:0] PH_HI   = 2'd2;
    localparam logic [1:0] PH_LO   = 2'd3;

    logic [WIDTH-1:0]    mag;
    logic [WIDTH-1:0]    mag_reg, mag_next;
    logic [PW-1:0]       acc_reg, acc_next;
    logic [PW-1:0]       rc_ext, lo_ext, hi_ext;
    logic [WIDTH-1:0]    quo_est, quo_d, rem_full;
    logic [WIDTH-1:0]    quo_reg, quo_next;
    logic [REM_BITS-1:0] rem_reg, rem_next;
    logic                neg_reg, neg_next;
    logic [1:0]          cnt_reg, cnt_next;

    assign mag      = dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
    assign rc_ext   = PW'(RECIP);
    assign lo_ext   = PW'(mag_reg[LO-1:0]);
    assign hi_ext   = PW'(mag_reg[WIDTH-1:LO]);
    assign quo_est  = WIDTH'(acc_reg[PW-1:SH]);
    assign quo_d    = quo_est * DIV_W;
    assign rem_full = mag_reg - quo_d;

    // low half of the product, high half, then quotient and remainder
    always_comb
    begin
        mag_next = mag_reg;
        acc_next = acc_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            neg_next = dividend[WIDTH-1];
            mag_next = mag;
            cnt_next = PH_LO;
        end
        else
        begin
            case (cnt_reg)
                PH_LO:
                begin
                    acc_next = lo_ext * rc_ext;
                    cnt_next = PH_HI;
                end
                PH_HI:
                begin
                    acc_next = acc_reg + ((hi_ext * rc_ext) << LO);
                    cnt_next = PH_FIX;
                end
                PH_FIX:
                begin
                    quo_next = quo_est;
                    rem_next = rem_full[REM_BITS-1:0];
                    cnt_next = PH_IDLE;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= PH_IDLE;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        acc_reg <= acc_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign done = (cnt_reg == PH_IDLE);

    // negative dividend: floor rounds away from zero when a remainder is left
    always_comb
    begin
        if (neg_reg && (rem_reg != '0))
        begin
            quotient  = ~quo_reg;
            remainder = DIV_R - rem_reg;
        end
        else if (neg_reg)
        begin
            quotient  = ~quo_reg + 1'b1;
            remainder = rem_reg;
        end
        else
        begin
            quotient  = quo_reg;
            remainder = rem_reg;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/crss_axis.sv
// Per-coordinate datapath: point window, coefficients, dividers and forward differencing.
`default_nettype none

module crss_axis #(
    parameter int STEPS      = crss_pkg::STEPS_DEFAULT,
    parameter int COORD_BITS = crss_pkg::COORD_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  crss_pkg::crss_cmd_t            cmd,
    input  logic signed [COORD_BITS-1:0]   point,
    output logic        [crss_pkg::OUT_BITS-1:0] sample,
    output logic                           div_done
);
    import crss_pkg::*;

    localparam int SB      = $clog2(STEPS + 1);
    localparam int W       = COORD_BITS + 2 * SB + 6;
    localparam int DIVISOR = 2 * STEPS * STEPS * STEPS;
    localparam int RB      = $clog2(DIVISOR + 1);

    localparam logic signed [W-1:0] S1 = W'(STEPS);
    localparam logic signed [W-1:0] S2 = W'(STEPS * STEPS);
    localparam logic signed [W-1:0] K2 = W'(2);
    localparam logic signed [W-1:0] K3 = W'(3);
    localparam logic signed [W-1:0] K4 = W'(4);
    localparam logic signed [W-1:0] K5 = W'(5);
    localparam logic signed [W-1:0] K6 = W'(6);
    localparam logic signed [W-1:0] OUT_MAX_W = W'(OUT_MAX);
    localparam logic [RB:0]         DIV_EXT   = (RB + 1)'(DIVISOR);

    logic signed [COORD_BITS-1:0] win_reg [4];

    logic signed [W-1:0] p0, p1, p2, p3;
    logic signed [W-1:0] ca, cb, cc;
    logic signed [W-1:0] d1n, d2n, d3n;

    logic [2:0]          done_v;
    logic signed [W-1:0] q1, q2, q3;
    logic [RB-1:0]       r1, r2, r3;

    logic signed [W-1:0] nq_reg, nq_next, aq_reg, aq_next, bq_reg, bq_next;
    logic [RB-1:0]       nr_reg, nr_next, ar_reg, ar_next, br_reg, br_next;
    logic [RB:0]         sum_n, sum_a, sum_b;
    logic                cy_n, cy_a, cy_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (cmd.shift)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= win_reg[3];
            win_reg[3] <= point;
        end
    end

    assign p0 = W'(win_reg[0]);
    assign p1 = W'(win_reg[1]);
    assign p2 = W'(win_reg[2]);
    assign p3 = W'(win_reg[3]);

    assign ca = p2 - p0;
    assign cb = K2 * p0 - K5 * p1 + K4 * p2 - p3;
    assign cc = K3 * p1 - p0 - K3 * p2 + p3;

    // first, second and third differences of N(k), scaled by 2*STEPS^3
    assign d1n = ca * S2 + cb * S1 + cc;
    assign d2n = K2 * cb * S1 + K6 * cc;
    assign d3n = K6 * cc;

    crss_div #(.WIDTH(W), .DIVISOR(DIVISOR)) u_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.coef),
        .dividend  (d1n),
        .done      (done_v[0]),
        .quotient  (q1),
        .remainder (r1)
    );

    crss_div #(.WIDTH(W), .DIVISOR(DIVISOR)) u_div2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.coef),
        .dividend  (d2n),
        .done      (done_v[1]),
        .quotient  (q2),
        .remainder (r2)
    );

    crss_div #(.WIDTH(W), .DIVISOR(DIVISOR)) u_div3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.coef),
        .dividend  (d3n),
        .done      (done_v[2]),
        .quotient  (q3),
        .remainder (r3)
    );

    assign div_done = &done_v;

    assign sum_n = {1'b0, nr_reg} + {1'b0, ar_reg};
    assign sum_a = {1'b0, ar_reg} + {1'b0, br_reg};
    assign sum_b = {1'b0, br_reg} + {1'b0, r3};
    assign cy_n  = (sum_n >= DIV_EXT);
    assign cy_a  = (sum_a >= DIV_EXT);
    assign cy_b  = (sum_b >= DIV_EXT);

    always_comb
    begin
        nq_next = nq_reg;
        nr_next = nr_reg;
        aq_next = aq_reg;
        ar_next = ar_reg;
        bq_next = bq_reg;
        br_next = br_reg;
        if (cmd.coef)
        begin
            nq_next = p1;
            nr_next = '0;
        end
        if (cmd.load_diff)
        begin
            aq_next = q1;
            ar_next = r1;
            bq_next = q2;
            br_next = r2;
        end
        if (cmd.step)
        begin
            nr_next = cy_n ? RB'(sum_n - DIV_EXT) : RB'(sum_n);
            nq_next = nq_reg + aq_reg + {{(W-1){1'b0}}, cy_n};
            ar_next = cy_a ? RB'(sum_a - DIV_EXT) : RB'(sum_a);
            aq_next = aq_reg + bq_reg + {{(W-1){1'b0}}, cy_a};
            br_next = cy_b ? RB'(sum_b - DIV_EXT) : RB'(sum_b);
            bq_next = bq_reg + q3 + {{(W-1){1'b0}}, cy_b};
        end
    end

    always_ff @(posedge clk)
    begin
        nq_reg <= nq_next;
        nr_reg <= nr_next;
        aq_reg <= aq_next;
        ar_reg <= ar_next;
        bq_reg <= bq_next;
        br_reg <= br_next;
    end

    always_comb
    begin
        if (nq_reg < 0)
        begin
            sample = '0;
        end
        else if (nq_reg > OUT_MAX_W)
        begin
            sample = OUT_BITS'(OUT_MAX);
        end
        else
        begin
            sample = nq_reg[OUT_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/crss_ctrl.sv
// Controller state machine: window fill, divider sequencing and sample count.
`default_nettype none

module crss_ctrl #(
    parameter int STEPS = crss_pkg::STEPS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  crss_pkg::crss_stat_t stat,
    output logic                 in_ready,
    output crss_pkg::crss_cmd_t  cmd
);
    import crss_pkg::*;

    localparam int KW = $clog2(STEPS + 1);
    localparam logic [2:0]    HELD_FULL = 3'd4;
    localparam logic [KW-1:0] K_LAST    = KW'(STEPS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_COEF = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_RUN  = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [2:0]    held_reg, held_next;
    logic [KW-1:0] k_reg, k_next;

    always_comb
    begin
        state_next = state_reg;
        held_next  = held_reg;
        k_next     = k_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    cmd.shift = 1'b1;
                    if (held_reg == HELD_FULL)
                    begin
                        if (stat.pen_down)
                        begin
                            state_next = ST_COEF;
                        end
                    end
                    else
                    begin
                        held_next = held_reg + 1'b1;
                    end
                end
            end
            ST_COEF:
            begin
                cmd.coef   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.load_diff = 1'b1;
                    k_next        = '0;
                    state_next    = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.last = (k_reg == K_LAST);
                if (stat.out_free)
                begin
                    cmd.step = 1'b1;
                    if (k_reg == K_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            held_reg  <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            k_reg     <= k_next;
        end
    end

endmodule

`default_nettype wire
